// ===== design/ldpm_pkg.sv =====
// Package for the lens distortion point mapper: fixed-point widths, the
// register index codes and the saturating helpers.
// Has no dependencies; every design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package ldpm_pkg;

    // Widths of the public fields
    localparam int PIX_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Q.20 working values: held within +-(2^47-1)
    localparam int Q_W       = 48;
    localparam int MAG_W     = 47;
    localparam int FRAC      = 20;
    localparam int COEF_FRAC = 12;
    localparam int SUM_W     = 51;   // room for four Q.20 terms plus one
    localparam int PROD_W    = 2 * MAG_W;
    localparam int WORD64    = 64;   // magnitude product limit of the format

    // Normalizing divider
    localparam int DIFF_W    = PIX_W + 5;
    localparam int DMAG_W    = DIFF_W - 1;
    localparam int DIV_W     = DMAG_W + FRAC;

    // Back mapping to pixels
    localparam int BACK_SH   = FRAC + 4;
    localparam int DPROD_W   = MAG_W + CFG_W;
    localparam int V_W       = 64;
    localparam int R_W       = V_W - BACK_SH;

    // Pipeline depth: divider input stage plus one stage per quotient bit,
    // the normalized coordinate register, then 27 stages to the output
    localparam int PIPE_LAT  = DIV_W + 29;

    typedef logic signed [Q_W-1:0]   q_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam q_t   Q_LIM   = q_t'(48'sh7FFF_FFFF_FFFF);
    localparam sum_t SUM_LIM = sum_t'(Q_LIM);
    localparam sum_t SUM_ONE = sum_t'(1) <<< FRAC;

    // Third radial coefficient, signed Q4.12, fixed at build time
    localparam logic signed [CFG_W-1:0] RADIAL_K3_Q12 = 16'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_FOCAL_X       = 3'd2,
        REG_FOCAL_Y       = 3'd3,
        REG_RADIAL_K1     = 3'd4,
        REG_RADIAL_K2     = 3'd5,
        REG_TANGENTIAL_P1 = 3'd6,
        REG_TANGENTIAL_P2 = 3'd7
    } cfg_reg_t;

    // Sign extend a Q.20 value for summing
    function automatic sum_t ext_q(input q_t a);
        return sum_t'(a);
    endfunction

    // Sign extend a Q4.12 coefficient to the working width
    function automatic q_t coef_q(input logic signed [CFG_W-1:0] k);
        return q_t'(k);
    endfunction

    // Clamp a sum to +-(2^47-1)
    function automatic q_t sat_q(input sum_t v);
        if (v > SUM_LIM) begin
            return Q_LIM;
        end else if (v < -SUM_LIM) begin
            return -Q_LIM;
        end
        return v[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/ldpm_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, sign carried along.
// Depends on ldpm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ldpm_div import ldpm_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [DMAG_W-1:0] mag_in,
    input  logic              neg_in,
    input  logic [CFG_W-1:0]  divisor,
    output logic [DIV_W-1:0]  quo,
    output logic              neg
);

    logic [CFG_W-1:0] rem_reg [0:DIV_W];
    logic [DIV_W-1:0] num_reg [0:DIV_W];
    logic [DIV_W-1:0] quo_reg [0:DIV_W];
    logic             neg_reg [0:DIV_W];

    // Input stage: dividend is the magnitude scaled by 2^20
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            num_reg[0] <= {mag_in, {FRAC{1'b0}}};
            quo_reg[0] <= '0;
            neg_reg[0] <= neg_in;
        end
    end

    // One compare and subtract per stage
    for (genvar g = 1; g <= DIV_W; g++) begin : g_step
        logic [CFG_W:0] trial;
        logic           ge;
        logic [CFG_W:0] diff;

        always_comb begin
            trial = {rem_reg[g-1], num_reg[g-1][DIV_W-1]};
            ge    = trial >= {1'b0, divisor};
            diff  = trial - {1'b0, divisor};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
                num_reg[g] <= {num_reg[g-1][DIV_W-2:0], 1'b0};
                quo_reg[g] <= {quo_reg[g-1][DIV_W-2:0], ge};
                neg_reg[g] <= neg_reg[g-1];
            end
        end
    end

    assign quo = quo_reg[DIV_W];
    assign neg = neg_reg[DIV_W];

endmodule

`default_nettype wire

// ===== design/ldpm_qmul.sv =====
// Four-stage fixed-point multiplier: sign-magnitude, 24-bit partial products,
// shift back by 20 or 12 bits truncating toward zero, clamp to +-(2^47-1).
// Depends on ldpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldpm_qmul import ldpm_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  logic coef_mode,   // 1: coefficient product, shift by 12
    input  q_t   a,
    input  q_t   b,
    output q_t   p
);

    localparam int LO_W = 24;
    localparam int HI_W = MAG_W - LO_W;

    logic [MAG_W-1:0]       ma_reg, mb_reg;
    logic                   neg1_reg, neg2_reg, neg3_reg;
    logic [2*LO_W-1:0]      pp_ll_reg;
    logic [LO_W+HI_W-1:0]   pp_lh_reg, pp_hl_reg;
    logic [2*HI_W-1:0]      pp_hh_reg;
    logic [PROD_W-1:0]      prod_reg;
    q_t                     p_reg;

    q_t                     a_abs, b_abs;
    logic [PROD_W-1:0]      shifted;
    logic                   big;
    logic [MAG_W-1:0]       m;
    q_t                     pv;

    // Stage 1: magnitudes and product sign
    always_comb begin
        a_abs = a[Q_W-1] ? -a : a;
        b_abs = b[Q_W-1] ? -b : b;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= a_abs[MAG_W-1:0];
            mb_reg   <= b_abs[MAG_W-1:0];
            neg1_reg <= a[Q_W-1] ^ b[Q_W-1];
        end
    end

    // Stage 2: partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg <= ma_reg[LO_W-1:0] * mb_reg[LO_W-1:0];
            pp_lh_reg <= ma_reg[LO_W-1:0] * mb_reg[MAG_W-1:LO_W];
            pp_hl_reg <= ma_reg[MAG_W-1:LO_W] * mb_reg[LO_W-1:0];
            pp_hh_reg <= ma_reg[MAG_W-1:LO_W] * mb_reg[MAG_W-1:LO_W];
            neg2_reg  <= neg1_reg;
        end
    end

    // Stage 3: full product
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(pp_ll_reg)
                      + ((PROD_W'(pp_lh_reg) + PROD_W'(pp_hl_reg)) << LO_W)
                      + (PROD_W'(pp_hh_reg) << (2 * LO_W));
            neg3_reg <= neg2_reg;
        end
    end

    // Stage 4: scale back, clamp, restore sign
    always_comb begin
        shifted = coef_mode ? (prod_reg >> COEF_FRAC) : (prod_reg >> FRAC);
        big     = (|prod_reg[PROD_W-1:WORD64]) || (|shifted[PROD_W-1:MAG_W]);
        m       = big ? Q_LIM[MAG_W-1:0] : shifted[MAG_W-1:0];
        pv      = {1'b0, m};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= neg3_reg ? -pv : pv;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== design/lens_distortion_point_map.sv =====
// Brown-Conrady point mapper (k1, k2, k3 radial, p1, p2 tangential), top level.
// Throughput one transaction per cycle while no result waits. Depth is set by
// the normalizing divider and the r^2 -> r^4 -> r^6 -> k3 multiplier chain.
// The whole pipeline stalls together while a result waits on m_ready.
// Reset clears the pipeline valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module lens_distortion_point_map import ldpm_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [PIX_W-1:0] s_pixel_x,
    input  logic signed [PIX_W-1:0] s_pixel_y,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [PIX_W-1:0] m_distorted_x,
    output logic signed [PIX_W-1:0] m_distorted_y,
    output logic                    m_saturated,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata
);

    localparam int LAT = PIPE_LAT;

    // Pipeline control
    logic           en;
    logic [LAT-1:0] vld_reg;

    // Configuration
    logic [CFG_W-1:0]        cen_reg [0:1];
    logic [CFG_W-1:0]        foc_reg [0:1];
    logic [CFG_W-1:0]        foc_eff [0:1];
    logic signed [CFG_W-1:0] k1_reg, k2_reg, p1_reg, p2_reg;

    // Shared datapath
    q_t xy_q, r4_q, r6_q, k1r2_q, k2r4_q, k3r6_q;
    q_t r2_reg, xy2_reg, radial_reg;
    q_t r2_dly_reg   [0:3];
    q_t k1r2_dly_reg [0:7];
    q_t k2r4_dly_reg [0:3];

    // Per-lane datapath (0: x, 1: y)
    logic signed [PIX_W-1:0] pix_in [0:1];
    logic [DIV_W-1:0]        quo [0:1];
    logic                    quo_neg [0:1];
    q_t                      coord_reg [0:1];
    q_t                      sq_q [0:1];
    q_t                      sq1_reg [0:1];
    q_t                      tsum_reg [0:1];
    q_t                      cross_q [0:1];
    q_t                      self_q [0:1];
    q_t                      rad_q [0:1];
    q_t                      crd_dly_reg [0:1][0:17];
    q_t                      cross_dly_reg [0:1][0:12];
    q_t                      self_dly_reg [0:1][0:11];
    q_t                      d_reg [0:1];
    logic [MAG_W-1:0]        dmag_reg [0:1];
    logic                    dneg_reg [0:1];
    logic [DPROD_W-1:0]      dprod_reg [0:1];
    logic                    dneg2_reg [0:1];
    logic signed [V_W-1:0]   v_reg [0:1];
    logic [PIX_W-1:0]        out_reg [0:1];
    logic                    clip_reg [0:1];

    // Global advance: moves unless the output register holds an untaken result
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_reg[0] <= 16'd2560;
            cen_reg[1] <= 16'd1920;
            foc_reg[0] <= 16'd4096;
            foc_reg[1] <= 16'd4096;
            k1_reg     <= '0;
            k2_reg     <= '0;
            p1_reg     <= '0;
            p2_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:      cen_reg[0] <= cfg_wdata;
                REG_CENTER_Y:      cen_reg[1] <= cfg_wdata;
                REG_FOCAL_X:       foc_reg[0] <= cfg_wdata;
                REG_FOCAL_Y:       foc_reg[1] <= cfg_wdata;
                REG_RADIAL_K1:     k1_reg     <= cfg_wdata;
                REG_RADIAL_K2:     k2_reg     <= cfg_wdata;
                REG_TANGENTIAL_P1: p1_reg     <= cfg_wdata;
                REG_TANGENTIAL_P2: p2_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign pix_in[0] = s_pixel_x;
    assign pix_in[1] = s_pixel_y;

    // ---------------------------------------------------------------
    // Lanes: normalize, square, tangential terms, back mapping
    // ---------------------------------------------------------------
    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] diff_abs;
        q_t                       qv;
        logic signed [CFG_W-1:0]  cross_coef;
        logic signed [CFG_W-1:0]  self_coef;
        q_t                       d_abs;
        logic signed [V_W-1:0]    sval;
        logic [V_W-1:0]           vmag;
        logic [R_W-1:0]           r;
        logic                     vneg;
        logic                     clip_pos;
        logic                     clip_neg;

        // A zero focal length acts as 1/16 pixel
        assign foc_eff[l] = (foc_reg[l] == '0) ? CFG_W'(1) : foc_reg[l];

        // Offset from the principal point, in Q.4
        always_comb begin
            diff     = $signed({pix_in[l][PIX_W-1], pix_in[l], 4'b0000})
                     - $signed({5'b00000, cen_reg[l]});
            diff_abs = diff[DIFF_W-1] ? -diff : diff;
        end

        ldpm_div u_div (
            .aclk    (aclk),
            .en      (en),
            .mag_in  (diff_abs[DMAG_W-1:0]),
            .neg_in  (diff[DIFF_W-1]),
            .divisor (foc_eff[l]),
            .quo     (quo[l]),
            .neg     (quo_neg[l])
        );

        // Normalized coordinate (t0)
        assign qv = q_t'({{(Q_W-DIV_W){1'b0}}, quo[l]});

        always_ff @(posedge aclk) begin
            if (en) begin
                coord_reg[l] <= quo_neg[l] ? -qv : qv;
            end
        end

        ldpm_qmul u_sq (
            .aclk (aclk), .en (en), .coef_mode (1'b0),
            .a (coord_reg[l]), .b (coord_reg[l]), .p (sq_q[l])
        );

        // r^2 + 2*x^2 (or 2*y^2) at t6
        always_ff @(posedge aclk) begin
            if (en) begin
                sq1_reg[l]  <= sq_q[l];
                tsum_reg[l] <= sat_q(ext_q(r2_reg) + ext_q(sq1_reg[l]) + ext_q(sq1_reg[l]));
            end
        end

        assign cross_coef = (l == 0) ? p1_reg : p2_reg;
        assign self_coef  = (l == 0) ? p2_reg : p1_reg;

        ldpm_qmul u_cross (
            .aclk (aclk), .en (en), .coef_mode (1'b1),
            .a (coef_q(cross_coef)), .b (xy2_reg), .p (cross_q[l])
        );

        ldpm_qmul u_self (
            .aclk (aclk), .en (en), .coef_mode (1'b1),
            .a (coef_q(self_coef)), .b (tsum_reg[l]), .p (self_q[l])
        );

        // Align coordinate and tangential terms with the radial factor
        always_ff @(posedge aclk) begin
            if (en) begin
                crd_dly_reg[l][0]   <= coord_reg[l];
                cross_dly_reg[l][0] <= cross_q[l];
                self_dly_reg[l][0]  <= self_q[l];
                for (int i = 1; i < 18; i++) begin
                    crd_dly_reg[l][i] <= crd_dly_reg[l][i-1];
                end
                for (int i = 1; i < 13; i++) begin
                    cross_dly_reg[l][i] <= cross_dly_reg[l][i-1];
                end
                for (int i = 1; i < 12; i++) begin
                    self_dly_reg[l][i] <= self_dly_reg[l][i-1];
                end
            end
        end

        ldpm_qmul u_rad (
            .aclk (aclk), .en (en), .coef_mode (1'b0),
            .a (crd_dly_reg[l][17]), .b (radial_reg), .p (rad_q[l])
        );

        // Distorted normalized coordinate, then magnitude
        always_comb begin
            d_abs = d_reg[l][Q_W-1] ? -d_reg[l] : d_reg[l];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[l]     <= sat_q(ext_q(rad_q[l]) + ext_q(cross_dly_reg[l][12])
                                      + ext_q(self_dly_reg[l][11]));
                dmag_reg[l]  <= d_abs[MAG_W-1:0];
                dneg_reg[l]  <= d_reg[l][Q_W-1];
                dprod_reg[l] <= dmag_reg[l] * foc_eff[l];
                dneg2_reg[l] <= dneg_reg[l];
                v_reg[l]     <= sval + $signed(V_W'({cen_reg[l], {FRAC{1'b0}}}));
            end
        end

        // Back to pixels: truncate toward zero, clip to 16 bits
        always_comb begin
            sval     = dneg2_reg[l] ? -$signed({1'b0, dprod_reg[l]})
                                    :  $signed({1'b0, dprod_reg[l]});
            vneg     = v_reg[l][V_W-1];
            vmag     = vneg ? -v_reg[l] : v_reg[l];
            r        = vmag[V_W-1:BACK_SH];
            clip_pos = !vneg && (r > R_W'(32767));
            clip_neg = vneg && (r > R_W'(32768));
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                clip_reg[l] <= clip_pos || clip_neg;
                if (clip_pos) begin
                    out_reg[l] <= 16'h7FFF;
                end else if (clip_neg) begin
                    out_reg[l] <= 16'h8000;
                end else begin
                    out_reg[l] <= vneg ? -r[PIX_W-1:0] : r[PIX_W-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared radial path
    // ---------------------------------------------------------------
    ldpm_qmul u_xy (
        .aclk (aclk), .en (en), .coef_mode (1'b0),
        .a (coord_reg[0]), .b (coord_reg[1]), .p (xy_q)
    );

    // r^2 and 2xy at t5
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg  <= sat_q(ext_q(sq_q[0]) + ext_q(sq_q[1]));
            xy2_reg <= sat_q(ext_q(xy_q) + ext_q(xy_q));
        end
    end

    ldpm_qmul u_r4 (
        .aclk (aclk), .en (en), .coef_mode (1'b0),
        .a (r2_reg), .b (r2_reg), .p (r4_q)
    );

    ldpm_qmul u_k1r2 (
        .aclk (aclk), .en (en), .coef_mode (1'b1),
        .a (coef_q(k1_reg)), .b (r2_reg), .p (k1r2_q)
    );

    ldpm_qmul u_r6 (
        .aclk (aclk), .en (en), .coef_mode (1'b0),
        .a (r4_q), .b (r2_dly_reg[3]), .p (r6_q)
    );

    ldpm_qmul u_k2r4 (
        .aclk (aclk), .en (en), .coef_mode (1'b1),
        .a (coef_q(k2_reg)), .b (r4_q), .p (k2r4_q)
    );

    ldpm_qmul u_k3r6 (
        .aclk (aclk), .en (en), .coef_mode (1'b1),
        .a (coef_q(RADIAL_K3_Q12)), .b (r6_q), .p (k3r6_q)
    );

    // Delay lines and the radial factor (t18)
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_dly_reg[0]   <= r2_reg;
            k1r2_dly_reg[0] <= k1r2_q;
            k2r4_dly_reg[0] <= k2r4_q;
            for (int i = 1; i < 4; i++) begin
                r2_dly_reg[i]   <= r2_dly_reg[i-1];
                k2r4_dly_reg[i] <= k2r4_dly_reg[i-1];
            end
            for (int i = 1; i < 8; i++) begin
                k1r2_dly_reg[i] <= k1r2_dly_reg[i-1];
            end
            radial_reg <= sat_q(SUM_ONE + ext_q(k1r2_dly_reg[7])
                                + ext_q(k2r4_dly_reg[3]) + ext_q(k3r6_q));
        end
    end

    assign m_distorted_x = out_reg[0];
    assign m_distorted_y = out_reg[1];
    assign m_saturated   = clip_reg[0] || clip_reg[1];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_distorted_x == 16'sh7FFF) || (m_distorted_x == -16'sh8000) ||
            (m_distorted_y == 16'sh7FFF) || (m_distorted_y == -16'sh8000))
        else $error("saturated set without a clipped coordinate");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0))
        else $error("pipeline not empty after reset");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

endmodule

`default_nettype wire

// ===== test/lens_distortion_point_map_tb.sv =====
// Testbench for lens_distortion_point_map: drives pixel transactions, predicts the
// distorted pixel in fixed point and checks every result field by field.
// Depends on ldpm_pkg and the lens_distortion_point_map RTL.
`timescale 1ns / 1ps

module lens_distortion_point_map_tb;
    import ldpm_pkg::*;

    localparam longint LIMV     = 64'sh7FFF_FFFF_FFFF;
    localparam int     LATENCY  = PIPE_LAT;
    localparam int     K3       = RADIAL_K3_Q12;

    typedef struct {
        logic signed [PIX_W-1:0] dx;
        logic signed [PIX_W-1:0] dy;
        logic                    sat;
    } point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [PIX_W-1:0] s_pixel_x = '0;
    logic signed [PIX_W-1:0] s_pixel_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [PIX_W-1:0] m_distorted_x;
    logic signed [PIX_W-1:0] m_distorted_y;
    logic m_saturated;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Shadow copy of the camera registers
    logic [15:0] cam_reg [0:7];
    point_t      pending_points [$];
    int          errors = 0;
    int          src_idle_pct = 0;
    int          dst_stall_pct = 0;
    int          hold_cycles = 0;

    lens_distortion_point_map u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_x(s_pixel_x), .s_pixel_y(s_pixel_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_distorted_x(m_distorted_x), .m_distorted_y(m_distorted_y),
        .m_saturated(m_saturated),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL lens_distortion_point_map");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint clamp47(input longint v);
        if (v > LIMV) return LIMV;
        if (v < -LIMV) return -LIMV;
        return v;
    endfunction

    // (a*b) >> sh toward zero, clamped
    function automatic longint fx_mul(input longint a, input longint b, input int sh);
        logic [127:0] p;
        longint unsigned ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = 128'(ma) * 128'(mb);
        if (p[127:64] != 0) m = LIMV;
        else begin
            m = p[63:0] >> sh;
            if (m > LIMV) m = LIMV;
        end
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint to_norm(input longint pix, input logic [15:0] c,
                                       input logic [15:0] f);
        longint fd, num;
        fd = (f == 0) ? 1 : longint'(f);
        num = (pix * 16 - longint'(c)) * (64'sd1 <<< FRAC);
        return clamp47(num / fd);
    endfunction

    function automatic longint to_pixel(input longint d, input logic [15:0] c,
                                        input logic [15:0] f, inout logic clip);
        longint fd, m, v, r, mv;
        fd = (f == 0) ? 1 : longint'(f);
        m = ((d < 0) ? -d : d) * fd;
        v = ((d < 0) ? -m : m) + longint'(c) * (64'sd1 <<< FRAC);
        mv = (v < 0) ? -v : v;
        r = (v < 0) ? -(mv >>> 24) : (mv >>> 24);
        if (r > 32767) begin clip = 1'b1; return 32767; end
        if (r < -32768) begin clip = 1'b1; return -32768; end
        return r;
    endfunction

    function automatic point_t distort_point(input logic signed [15:0] px,
                                             input logic signed [15:0] py);
        longint x, y, xx, yy, xy, r2, r4, r6, radial, xy2, xd, yd, k1, k2, p1, p2;
        point_t pt;
        logic clip;
        k1 = longint'($signed(cam_reg[REG_RADIAL_K1]));
        k2 = longint'($signed(cam_reg[REG_RADIAL_K2]));
        p1 = longint'($signed(cam_reg[REG_TANGENTIAL_P1]));
        p2 = longint'($signed(cam_reg[REG_TANGENTIAL_P2]));
        x = to_norm(longint'(px), cam_reg[REG_CENTER_X], cam_reg[REG_FOCAL_X]);
        y = to_norm(longint'(py), cam_reg[REG_CENTER_Y], cam_reg[REG_FOCAL_Y]);
        xx = fx_mul(x, x, FRAC);
        yy = fx_mul(y, y, FRAC);
        xy = fx_mul(x, y, FRAC);
        r2 = clamp47(xx + yy);
        r4 = fx_mul(r2, r2, FRAC);
        r6 = fx_mul(r4, r2, FRAC);
        radial = clamp47((64'sd1 <<< FRAC) + fx_mul(k1, r2, COEF_FRAC)
                         + fx_mul(k2, r4, COEF_FRAC) + fx_mul(longint'(K3), r6, COEF_FRAC));
        xy2 = clamp47(2 * xy);
        xd = clamp47(fx_mul(x, radial, FRAC) + fx_mul(p1, xy2, COEF_FRAC)
                     + fx_mul(p2, clamp47(r2 + 2 * xx), COEF_FRAC));
        yd = clamp47(fx_mul(y, radial, FRAC) + fx_mul(p1, clamp47(r2 + 2 * yy), COEF_FRAC)
                     + fx_mul(p2, xy2, COEF_FRAC));
        clip = 1'b0;
        pt.dx = 16'(to_pixel(xd, cam_reg[REG_CENTER_X], cam_reg[REG_FOCAL_X], clip));
        pt.dy = 16'(to_pixel(yd, cam_reg[REG_CENTER_Y], cam_reg[REG_FOCAL_Y], clip));
        pt.sat = clip;
        return pt;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cam_reg[idx] = val;
    endtask

    // Sends one point; valid stays high while items follow back to back
    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_x <= px;
        s_pixel_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_points.insert(pending_points.size(), distort_point(px, py));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    // Receiver side: random or long stalls
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        point_t exp_pt;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", m_distorted_x, m_distorted_y);
                errors++;
            end else begin
                exp_pt = pending_points.pop_front();
                if (m_distorted_x !== exp_pt.dx) begin
                    $error("distorted_x exp %0d got %0d", exp_pt.dx, m_distorted_x);
                    errors++;
                end
                if (m_distorted_y !== exp_pt.dy) begin
                    $error("distorted_y exp %0d got %0d", exp_pt.dy, m_distorted_y);
                    errors++;
                end
                if (m_saturated !== exp_pt.sat) begin
                    $error("saturated exp %0d got %0d", exp_pt.sat, m_saturated);
                    errors++;
                end
            end
        end
    end

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom());
            default: return 16'($signed($urandom_range(1600)) - 800);
        endcase
    endfunction

    // Mostly pixels near the frame, sometimes anywhere
    task automatic send_random(input int n);
        repeat (n) begin
            if ($urandom_range(9) < 7)
                send_point(16'($urandom_range(640)), 16'($urandom_range(480)));
            else
                send_point(16'($urandom()), 16'($urandom()));
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_defaults();
        logic signed [15:0] ext [4] = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1};
        foreach (ext[i]) foreach (ext[j]) send_point(ext[i], ext[j]);
        send_point(16'sd160, 16'sd120);
        send_point(16'sd320, 16'sd240);
        drain();
    endtask

    task automatic test_special_cases();
        write_reg(REG_FOCAL_X, 16'd0);      // zero focal acts as one
        write_reg(REG_FOCAL_Y, 16'd0);
        write_reg(REG_RADIAL_K1, 16'h7FFF);
        write_reg(REG_RADIAL_K2, 16'h8000);
        write_reg(REG_TANGENTIAL_P1, 16'h7FFF);
        write_reg(REG_TANGENTIAL_P2, 16'h8000);
        send_point(16'sh7FFF, -16'sh8000);  // intermediate overflow
        send_point(16'sd5, 16'sd3);
        send_point(16'sd0, 16'sd0);
        drain();
        write_reg(REG_CENTER_X, 16'hFFFF);
        write_reg(REG_CENTER_Y, 16'h0000);
        write_reg(REG_FOCAL_X, 16'hFFFF);
        write_reg(REG_FOCAL_Y, 16'd16);
        write_reg(REG_RADIAL_K1, 16'h0000);
        write_reg(REG_RADIAL_K2, 16'h0000);
        write_reg(REG_TANGENTIAL_P1, 16'h0000);
        write_reg(REG_TANGENTIAL_P2, 16'h0000);
        send_point(16'sd100, 16'sh7FFF);
        send_point(-16'sh8000, 16'sd1);
        drain();
    endtask

    task automatic test_random_phases();
        int idle_src [4] = '{0, 76, 0, 32};
        int idle_dst [4] = '{0, 0, 76, 32};
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 8; r++) begin
                if (r < 4)
                    write_reg(cfg_reg_t'(r), (r < 2) ? 16'($urandom_range(65535))
                                                     : 16'($urandom_range(65535, 16)));
                else
                    write_reg(cfg_reg_t'(r), rand_coef());
            end
            src_idle_pct = idle_src[ph % 4];
            dst_stall_pct = idle_dst[ph % 4];
            send_random(220);
            drain();
        end
        src_idle_pct = 0;
        dst_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_CENTER_X, 16'd5120);
        write_reg(REG_CENTER_Y, 16'd3840);
        write_reg(REG_RADIAL_K1, 16'hFC00);
        @(negedge aclk);
        hold_cycles = 300;                  // long receiver hold-off, input fills
        send_random(150);
        drain();
        send_random(40);
        drain();                            // sender waits for every result
        send_random(40);
        drain();
    endtask

    initial begin
        for (int i = 0; i < 8; i++) cam_reg[i] = 16'h0;
        cam_reg[REG_CENTER_X] = 16'd2560;
        cam_reg[REG_CENTER_Y] = 16'd1920;
        cam_reg[REG_FOCAL_X]  = 16'd4096;
        cam_reg[REG_FOCAL_Y]  = 16'd4096;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_defaults();
        test_special_cases();
        test_random_phases();
        test_backpressure();
        if (errors == 0 && pending_points.size() == 0) begin
            $display("PASS lens_distortion_point_map");
        end else begin
            $display("FAIL lens_distortion_point_map");
        end
        $finish;
    end

endmodule
